// File: hdl/spf_pkg.sv
// Shared types and constants for the servo bus packet framer.
// Used by every module in hdl/; depends on nothing.
package spf_pkg;

  // Largest parameter count; larger counts are clamped to this value.
  localparam int unsigned MaxParams = 16;
  // Width of the parameter count field and the remaining-parameter counter.
  localparam int unsigned CountW = 5;
  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  // Fixed bytes of the packet.
  localparam logic [7:0] SyncByte = 8'hff;
  localparam logic [7:0] LenOffset = 8'd2;

  // Reset values of the configuration registers.
  localparam logic       GuardEnableReset = 1'b1;
  localparam logic [7:0] GuardLimitReset = 8'd5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GUARD_ENABLE = 2'd0,
    REG_GUARD_LIMIT  = 2'd1
  } cfg_reg_e;

  // One input word.
  typedef struct packed {
    logic              first;
    logic [7:0]        servo_id;
    logic [7:0]        instruction;
    logic [CountW-1:0] param_count;
    logic [7:0]        param_byte;
  } in_item_t;

  // One output word.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_packet;
    logic       rejected;
  } out_item_t;

  // Command kinds passed from front to back.
  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_PARAM  = 2'd2
  } cmd_kind_e;

  // One command: a group of output bytes the back end emits in order.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] servo_id;
    logic [7:0] len;
    logic [7:0] instruction;
    logic       has_param;
    logic [7:0] param;
    logic       has_csum;
    logic [7:0] csum;
  } cmd_t;

  // Byte position within a packet, as walked by the back end.
  typedef enum logic [2:0] {
    ST_SYNC0 = 3'd0,
    ST_SYNC1 = 3'd1,
    ST_ID    = 3'd2,
    ST_LEN   = 3'd3,
    ST_INSTR = 3'd4,
    ST_PARAM = 3'd5,
    ST_CSUM  = 3'd6
  } step_e;

  // Queue status seen by the producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: hdl/spf_front.sv
// Front end of the servo bus packet framer: configuration, input acceptance,
// packet state and checksum tracking. Depends on spf_pkg.
module spf_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  spf_pkg::in_item_t       in_data_i,
  input  spf_pkg::queue_status_t  queue_status_i,
  output logic                    push_o,
  output spf_pkg::cmd_t           cmd_o
);

  logic                      guard_enable_q;
  logic [7:0]                guard_limit_q;
  logic [7:0]                running_sum_q, running_sum_d;
  logic [spf_pkg::CountW-1:0] params_left_q, params_left_d;
  logic                      in_packet_q, in_packet_d;
  logic                      dropping_q, dropping_d;

  logic                      in_fire;
  logic [spf_pkg::CountW-1:0] count_sat;
  logic [7:0]                len;
  logic [7:0]                hdr_sum;
  logic [7:0]                param_sum;
  logic [7:0]                base_sum;
  logic [spf_pkg::CountW-1:0] left_after;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !queue_status_i.full;
  assign in_fire     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_enable_q <= spf_pkg::GuardEnableReset;
      guard_limit_q  <= spf_pkg::GuardLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spf_pkg::REG_GUARD_ENABLE: guard_enable_q <= cfg_data_i[0];
        spf_pkg::REG_GUARD_LIMIT:  guard_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Header arithmetic with the parameter count clamped to the maximum.
  assign count_sat = (in_data_i.param_count > spf_pkg::CountW'(spf_pkg::MaxParams)) ?
                     spf_pkg::CountW'(spf_pkg::MaxParams) : in_data_i.param_count;
  assign len       = 8'(count_sat) + spf_pkg::LenOffset;
  assign hdr_sum   = in_data_i.servo_id + len + in_data_i.instruction;

  // The sum a parameter adds onto: the fresh header sum or the running sum.
  assign base_sum   = in_data_i.first ? hdr_sum : running_sum_q;
  assign param_sum  = base_sum + in_data_i.param_byte;
  assign left_after = (in_data_i.first ? count_sat : params_left_q) - 1'b1;

  // Classify the word, update packet state and build the command.
  always_comb begin
    running_sum_d   = running_sum_q;
    params_left_d   = params_left_q;
    in_packet_d     = in_packet_q;
    dropping_d      = dropping_q;
    push_o          = 1'b0;
    cmd_o           = '0;
    cmd_o.kind      = spf_pkg::CMD_PARAM;
    cmd_o.servo_id  = in_data_i.servo_id;
    cmd_o.len       = len;
    cmd_o.instruction = in_data_i.instruction;
    cmd_o.param     = in_data_i.param_byte;
    cmd_o.csum      = ~param_sum;
    if (in_fire) begin
      if (in_data_i.first) begin
        dropping_d = 1'b0;
        push_o     = 1'b1;
        if (count_sat != '0 && guard_enable_q &&
            in_data_i.param_byte <= guard_limit_q) begin
          // Guard refusal: one rejection word, rest of the packet dropped.
          cmd_o.kind    = spf_pkg::CMD_REJECT;
          running_sum_d = '0;
          params_left_d = left_after;
          in_packet_d   = left_after != '0;
          dropping_d    = left_after != '0;
        end else if (count_sat == '0) begin
          // Header followed directly by the checksum.
          cmd_o.kind    = spf_pkg::CMD_HEADER;
          cmd_o.has_csum = 1'b1;
          cmd_o.csum    = ~hdr_sum;
          running_sum_d = hdr_sum;
          params_left_d = '0;
          in_packet_d   = 1'b0;
        end else begin
          // Header plus first parameter, checksum if it is also the last.
          cmd_o.kind      = spf_pkg::CMD_HEADER;
          cmd_o.has_param = 1'b1;
          cmd_o.has_csum  = left_after == '0;
          running_sum_d   = param_sum;
          params_left_d   = left_after;
          in_packet_d     = left_after != '0;
        end
      end else if (!in_packet_q || params_left_q == '0) begin
        in_packet_d = 1'b0;
        dropping_d  = 1'b0;
      end else if (dropping_q) begin
        // Silently consume a parameter of a refused packet.
        params_left_d = left_after;
        if (left_after == '0) begin
          in_packet_d = 1'b0;
          dropping_d  = 1'b0;
        end
      end else begin
        // Middle or last parameter of an open packet.
        push_o          = 1'b1;
        cmd_o.has_param = 1'b1;
        cmd_o.has_csum  = left_after == '0;
        running_sum_d   = param_sum;
        params_left_d   = left_after;
        in_packet_d     = left_after != '0;
      end
    end
  end

  // Packet state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      params_left_q <= '0;
      in_packet_q   <= 1'b0;
      dropping_q    <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      params_left_q <= params_left_d;
      in_packet_q   <= in_packet_d;
      dropping_q    <= dropping_d;
    end
  end

endmodule

// File: hdl/spf_cmd_queue.sv
// Small command queue between the front and back ends of the framer.
// Depends on spf_pkg for the command type and depth.
module spf_cmd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  spf_pkg::cmd_t           cmd_i,
  input  logic                    pop_i,
  output spf_pkg::cmd_t           head_o,
  output spf_pkg::queue_status_t  status_o
);

  spf_pkg::cmd_t                entries_q [spf_pkg::QueueDepth];
  logic [spf_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [spf_pkg::QueuePtrW:0]   count_q;

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = count_q == (spf_pkg::QueuePtrW+1)'(spf_pkg::QueueDepth);
  assign status_o.empty = count_q == '0;

  // Storage; entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/spf_back.sv
// Back end of the framer: walks each queued command byte by byte into the
// output register. Depends on spf_pkg.
module spf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spf_pkg::cmd_t           head_i,
  input  spf_pkg::queue_status_t  queue_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output spf_pkg::out_item_t      out_data_o
);

  spf_pkg::step_e     step_q, step_d, cur_step, next_step;
  logic               active_q, active_d;
  logic               out_valid_q, out_valid_d;
  spf_pkg::out_item_t out_q, out_d;
  logic               load;
  logic               last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A word may be produced when the queue has one and the output slot frees.
  assign load = !queue_status_i.empty && (!out_valid_q || out_ready_i);

  // Step of the current command: continue, or start a fresh one.
  always_comb begin
    if (active_q) begin
      cur_step = step_q;
    end else if (head_i.kind == spf_pkg::CMD_PARAM) begin
      cur_step = spf_pkg::ST_PARAM;
    end else begin
      cur_step = spf_pkg::ST_SYNC0;
    end
  end

  // Byte selection, end detection and step sequencing.
  always_comb begin
    out_d     = '0;
    last      = 1'b0;
    next_step = cur_step;
    if (head_i.kind == spf_pkg::CMD_REJECT) begin
      out_d.end_of_packet = 1'b1;
      out_d.rejected      = 1'b1;
      last                = 1'b1;
    end else begin
      unique case (cur_step)
        spf_pkg::ST_SYNC0: begin
          out_d.tx_byte = spf_pkg::SyncByte;
          next_step     = spf_pkg::ST_SYNC1;
        end
        spf_pkg::ST_SYNC1: begin
          out_d.tx_byte = spf_pkg::SyncByte;
          next_step     = spf_pkg::ST_ID;
        end
        spf_pkg::ST_ID: begin
          out_d.tx_byte = head_i.servo_id;
          next_step     = spf_pkg::ST_LEN;
        end
        spf_pkg::ST_LEN: begin
          out_d.tx_byte = head_i.len;
          next_step     = spf_pkg::ST_INSTR;
        end
        spf_pkg::ST_INSTR: begin
          out_d.tx_byte = head_i.instruction;
          next_step     = head_i.has_param ? spf_pkg::ST_PARAM : spf_pkg::ST_CSUM;
        end
        spf_pkg::ST_PARAM: begin
          out_d.tx_byte = head_i.param;
          next_step     = spf_pkg::ST_CSUM;
          last          = !head_i.has_csum;
        end
        spf_pkg::ST_CSUM: begin
          out_d.tx_byte       = head_i.csum;
          out_d.end_of_packet = 1'b1;
          last                = 1'b1;
        end
        default: begin
          last = 1'b1;
        end
      endcase
    end
  end

  // Next state of the sequencer and the output register.
  always_comb begin
    step_d      = step_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (last) begin
        pop_o    = 1'b1;
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = next_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= spf_pkg::ST_SYNC0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

// File: hdl/servo_bus_packet_framer_top.sv
// Top level of the servo bus packet framer: front end, command queue and
// back end. Depends on spf_pkg, spf_front, spf_cmd_queue and spf_back.
//
// Usage: each input word carries one parameter byte; a word with first set
// also carries the servo id, instruction and parameter count and opens a
// packet. The output channel delivers one byte per word: FF FF, id, length,
// instruction, parameters, then the checksum flagged with end_of_packet. A
// packet refused by the address guard gives a single word with rejected and
// end_of_packet set, and its remaining parameter words are swallowed.
// The configuration channel writes the guard enable (index 0) and the guard
// limit (index 1); it is always ready and takes effect on the next word.
// Throughput: one input word per cycle while the four-entry command queue
// has room; the output side drains one byte per cycle while out_ready_i is
// high, so header bursts of up to seven bytes are absorbed by the queue and
// stall input only when it fills. With the queue empty and the output free,
// an accepted word is written into the command queue and its first byte is
// then loaded into the output register, where it can be taken. When the
// receiver stalls, the output word holds and the queue fills, after which
// in_ready_o drops. Reset empties the queue, clears the packet state and
// restores the guard to enabled with limit 5.
module servo_bus_packet_framer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spf_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spf_pkg::out_item_t  out_data_o
);

  logic                   push;
  logic                   pop;
  spf_pkg::cmd_t          cmd;
  spf_pkg::cmd_t          head;
  spf_pkg::queue_status_t queue_status;

  spf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  spf_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (queue_status)
  );

  spf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

`ifndef ASSERT_OFF
  // The front never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !queue_status.full)
    else $error("command pushed into a full queue");

  // The back never retires a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !queue_status.empty)
    else $error("command popped from an empty queue");

  // A rejection word is a zero byte that closes the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |->
      out_data_o.end_of_packet && out_data_o.tx_byte == 8'd0)
    else $error("malformed rejection word");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for servo_bus_packet_framer_top: a directed table,
// then random packet traffic under several guard settings and idling patterns.
// Depends on spf_pkg and the framer RTL; every word is checked against a local model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam int CycleLimit  = 250000;
  localparam int DrainCycles = 16;
  localparam int PhaseWords  = 40;
  localparam int NumPhases   = 6;
  localparam int StimRows    = 21;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_SILENT  = 2'd1,
    ROW_REFUSED = 2'd2
  } row_chk_e;

  typedef struct packed {
    row_chk_e chk;
    in_item_t word;
  } stim_row_t;

  // Directed rows, run with the guard at its reset setting (enabled, limit 5).
  localparam stim_row_t StimTab [StimRows] = '{
    // Parameter word with no packet open after reset.
    '{ROW_SILENT,  '{1'b0, 8'h00, 8'h00, 5'd0,  8'h00}},
    // Zero parameters: the guard is skipped even with a low byte.
    '{ROW_PREDICT, '{1'b1, 8'h01, 8'h03, 5'd0,  8'h00}},
    // One above the limit passes.
    '{ROW_PREDICT, '{1'b1, 8'hff, 8'hff, 5'd1,  8'h06}},
    // At the limit: refused, and the second parameter is swallowed.
    '{ROW_REFUSED, '{1'b1, 8'h00, 8'h00, 5'd2,  8'h05}},
    '{ROW_SILENT,  '{1'b0, 8'hff, 8'hff, 5'd31, 8'haa}},
    '{ROW_SILENT,  '{1'b0, 8'h00, 8'h00, 5'd0,  8'h55}},
    '{ROW_PREDICT, '{1'b1, 8'ha5, 8'h5a, 5'd3,  8'hff}},
    '{ROW_PREDICT, '{1'b0, 8'h00, 8'h00, 5'd0,  8'h00}},
    // New packet while one is open; count saturates in the length byte.
    '{ROW_PREDICT, '{1'b1, 8'h12, 8'h02, 5'd31, 8'h80}},
    '{ROW_PREDICT, '{1'b0, 8'h00, 8'h00, 5'd0,  8'h01}},
    '{ROW_PREDICT, '{1'b0, 8'h00, 8'h00, 5'd0,  8'hfe}},
    // Refusal that also abandons the open packet.
    '{ROW_REFUSED, '{1'b1, 8'hfe, 8'h83, 5'd2,  8'h00}},
    // New packet abandons the one being swallowed.
    '{ROW_PREDICT, '{1'b1, 8'h03, 8'h03, 5'd2,  8'h06}},
    '{ROW_PREDICT, '{1'b0, 8'h00, 8'h00, 5'd0,  8'hff}},
    // Single refused parameter leaves nothing to swallow.
    '{ROW_REFUSED, '{1'b1, 8'h07, 8'h01, 5'd1,  8'h05}},
    '{ROW_SILENT,  '{1'b0, 8'h00, 8'h00, 5'd0,  8'h03}},
    '{ROW_PREDICT, '{1'b1, 8'h00, 8'h00, 5'd0,  8'hff}},
    '{ROW_PREDICT, '{1'b1, 8'hff, 8'hff, 5'd16, 8'hff}},
    '{ROW_PREDICT, '{1'b0, 8'hff, 8'hff, 5'd31, 8'hff}},
    '{ROW_PREDICT, '{1'b1, 8'h5a, 8'ha5, 5'd17, 8'hc3}},
    '{ROW_PREDICT, '{1'b0, 8'h00, 8'h00, 5'd0,  8'h3c}}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  servo_bus_packet_framer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Model state: guard setting and the packet being framed.
  logic              guard_en_q;
  logic [7:0]        guard_lim_q;
  logic [7:0]        sum_acc;
  logic [CountW-1:0] params_rem;
  logic              pkt_open;
  logic              pkt_drop;

  out_item_t tx_expect_q[$];
  int        err_cnt;
  int        cycle_cnt;
  int        tx_idle_pct;
  int        rx_stall_pct;
  int        stall_order;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_item_t tx_word(logic [7:0] b, logic eop, logic rej);
    out_item_t w;
    w.tx_byte       = b;
    w.end_of_packet = eop;
    w.rejected      = rej;
    return w;
  endfunction

  function automatic in_item_t mk_in(logic f, logic [7:0] id, logic [7:0] ins,
                                     logic [CountW-1:0] cnt, logic [7:0] pb);
    in_item_t w;
    w.first       = f;
    w.servo_id    = id;
    w.instruction = ins;
    w.param_count = cnt;
    w.param_byte  = pb;
    return w;
  endfunction

  // Emit one parameter byte and, after the last one, the checksum.
  function automatic void emit_param(logic [7:0] pb, ref out_item_t q[$]);
    q.push_back(tx_word(pb, 1'b0, 1'b0));
    sum_acc    = sum_acc + pb;
    params_rem = params_rem - 1'b1;
    if (params_rem == '0) begin
      q.push_back(tx_word(~sum_acc, 1'b1, 1'b0));
      pkt_open = 1'b0;
    end
  endfunction

  // Bytes that one accepted input word causes on the servo line.
  function automatic void frame_word(in_item_t w, ref out_item_t q[$]);
    logic [CountW-1:0] cnt;
    logic [7:0]        len;
    cnt = w.param_count;
    if (w.first) begin
      if (cnt > MaxParams) cnt = CountW'(MaxParams);
      len        = {3'b000, cnt} + LenOffset;
      pkt_open   = 1'b0;
      pkt_drop   = 1'b0;
      params_rem = '0;
      sum_acc    = '0;
      if (cnt != '0 && guard_en_q && w.param_byte <= guard_lim_q) begin
        params_rem = cnt - 1'b1;
        if (params_rem != '0) begin
          pkt_open = 1'b1;
          pkt_drop = 1'b1;
        end
        q.push_back(tx_word(8'h00, 1'b1, 1'b1));
        return;
      end
      q.push_back(tx_word(SyncByte, 1'b0, 1'b0));
      q.push_back(tx_word(SyncByte, 1'b0, 1'b0));
      q.push_back(tx_word(w.servo_id, 1'b0, 1'b0));
      q.push_back(tx_word(len, 1'b0, 1'b0));
      q.push_back(tx_word(w.instruction, 1'b0, 1'b0));
      sum_acc = w.servo_id + len + w.instruction;
      if (cnt == '0) begin
        q.push_back(tx_word(~sum_acc, 1'b1, 1'b0));
        return;
      end
      pkt_open   = 1'b1;
      params_rem = cnt;
      emit_param(w.param_byte, q);
    end else if (!pkt_open || params_rem == '0) begin
      pkt_open = 1'b0;
      pkt_drop = 1'b0;
    end else if (pkt_drop) begin
      params_rem = params_rem - 1'b1;
      if (params_rem == '0) begin
        pkt_open = 1'b0;
        pkt_drop = 1'b0;
      end
    end else begin
      emit_param(w.param_byte, q);
    end
  endfunction

  // Offer one word, with optional idle cycles first. Called and returns at a falling edge.
  task automatic send_word(in_item_t w, row_chk_e chk);
    out_item_t pend[$];
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    frame_word(w, pend);
    case (chk)
      ROW_SILENT:  pend.delete();
      ROW_REFUSED: begin
        pend.delete();
        pend.push_back(tx_word(8'h00, 1'b1, 1'b1));
      end
      default: ;
    endcase
    foreach (pend[i]) tx_expect_q.push_back(pend[i]);
    @(negedge clk_i);
  endtask

  // One random packet: mostly well formed, some cut short, some stray words.
  task automatic send_random_packet(inout int sent);
    int         kind;
    int         r;
    int         n_par;
    logic [4:0] cnt;
    logic [7:0] pb;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_word(mk_in(1'b0, 8'($urandom), 8'($urandom), CountW'($urandom), 8'($urandom)),
                ROW_PREDICT);
      sent++;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 10) cnt = 5'd0;
    else if (r < 70) cnt = 5'($urandom_range(1, 6));
    else if (r < 92) cnt = 5'($urandom_range(7, MaxParams));
    else cnt = 5'($urandom_range(MaxParams + 1, 31));
    // Bias the first parameter toward the guard boundary.
    r = $urandom_range(0, 99);
    if (r < 30) pb = 8'($urandom_range(0, guard_lim_q));
    else if (r < 40) pb = guard_lim_q + 8'd1;
    else pb = 8'($urandom);
    n_par = (cnt > MaxParams) ? MaxParams : cnt;
    if (kind < 18 && n_par > 1) n_par = $urandom_range(1, n_par - 1);
    send_word(mk_in(1'b1, 8'($urandom), 8'($urandom), cnt, pb), ROW_PREDICT);
    sent++;
    for (int i = 1; i < n_par; i++) begin
      send_word(mk_in(1'b0, 8'($urandom), 8'($urandom), CountW'($urandom), 8'($urandom)),
                ROW_PREDICT);
      sent++;
    end
  endtask

  // Write both guard registers back to back. Called only while idle.
  task automatic set_guard(logic en, logic [7:0] lim);
    cfg_reg_e idx;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_GUARD_ENABLE : REG_GUARD_LIMIT;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= (idx == REG_GUARD_ENABLE) ? {7'd0, en} : lim;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx == REG_GUARD_ENABLE) guard_en_q = en;
      else guard_lim_q = lim;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait for every expected word, then let words that cause no output settle.
  task automatic drain();
    while (tx_expect_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_order != 0) begin
        hold_left   = stall_order;
        stall_order = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Compare each delivered word with the oldest expected one.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tx_expect_q.size() == 0) begin
        $error("unexpected word: tx_byte %h end_of_packet %b rejected %b",
               out_data_o.tx_byte, out_data_o.end_of_packet, out_data_o.rejected);
        err_cnt++;
      end else begin
        want = tx_expect_q.pop_front();
        if (out_data_o.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, out_data_o.tx_byte);
          err_cnt++;
        end
        if (out_data_o.end_of_packet !== want.end_of_packet) begin
          $error("end_of_packet: expected %b, got %b", want.end_of_packet,
                 out_data_o.end_of_packet);
          err_cnt++;
        end
        if (out_data_o.rejected !== want.rejected) begin
          $error("rejected: expected %b, got %b", want.rejected, out_data_o.rejected);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** servo_bus_packet_framer_top: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int sent;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_GUARD_ENABLE;
    cfg_data_i   = 8'h00;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    err_cnt      = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    stall_order  = 0;
    guard_en_q   = GuardEnableReset;
    guard_lim_q  = GuardLimitReset;
    sum_acc      = '0;
    params_rem   = '0;
    pkt_open     = 1'b0;
    pkt_drop     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < StimRows; i++) send_word(StimTab[i].word, StimTab[i].chk);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      // Guard setting per phase, extremes included.
      case (p)
        0: set_guard(1'b0, 8'h00);
        1: set_guard(1'b1, 8'h00);
        2: set_guard(1'b1, 8'hff);
        3: set_guard(1'b1, 8'($urandom));
        4: set_guard(1'b0, 8'hff);
        default: set_guard(1'b1, 8'($urandom_range(0, 64)));
      endcase
      // Idling pattern: none, sender, receiver, both.
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      // Long receiver hold-off so the queue fills and input stalls.
      if (p == 4) stall_order = 400;
      sent = 0;
      while (sent < PhaseWords) send_random_packet(sent);
      in_valid_i <= 1'b0;
      drain();
    end

    if (err_cnt == 0) begin
      $display("** servo_bus_packet_framer_top: PASSED **");
    end else begin
      $display("** servo_bus_packet_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
